// ===== src/ldpc_layered_min_sum_check_node_macros.svh =====
// assertion macros used by the check-node back end
`ifndef LDPC_LAYERED_MIN_SUM_CHECK_NODE_MACROS_SVH
`define LDPC_LAYERED_MIN_SUM_CHECK_NODE_MACROS_SVH

// property that holds at every clock edge out of reset
`define CN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// consequent checked in the cycle after the antecedent
`define CN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/ldpc_cn_pkg.sv =====
// types and constants of the layered min-sum check-node processor
package ldpc_cn_pkg;

  localparam int LLR_W       = 8;
  localparam int MAG_W       = 7;
  localparam int NODE_W      = 7;
  localparam int LANE_W      = 9;
  localparam int OP_W        = 2;
  localparam int LIFT_REG_W  = 9;
  localparam int SCALE_W     = 8;
  localparam int PROMO_W     = 7;
  localparam int CFG_W       = 9;
  localparam int CFG_IDX_W   = 2;
  localparam int QUEUE_DEPTH = 2;
  localparam int PROD_W      = MAG_W + SCALE_W;

  localparam int LLR_SAT = 120;
  localparam int LLR_INF = 127;

  localparam logic signed [LLR_W-1:0] INF_P = LLR_W'(LLR_INF);
  localparam logic signed [LLR_W-1:0] INF_N = LLR_W'(-LLR_INF);
  localparam logic signed [LLR_W-1:0] SAT_P = LLR_W'(LLR_SAT);
  localparam logic signed [LLR_W-1:0] SAT_N = LLR_W'(-LLR_SAT);
  localparam logic [MAG_W-1:0]        INF_MAG = MAG_W'(LLR_INF);
  localparam logic [PROD_W-1:0]       ROUND_HALF = PROD_W'(1) << (SCALE_W - 1);

  localparam logic [LIFT_REG_W-1:0] LIFT_RST  = LIFT_REG_W'(384);
  localparam logic [SCALE_W-1:0]    SCALE_RST = SCALE_W'(205);
  localparam logic [PROMO_W-1:0]    PROMO_RST = PROMO_W'(120);

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR   = 2'd0,
    OP_ANALYZE = 2'd1,
    OP_UPDATE  = 2'd2
  } cn_op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LIFT    = 2'd0,
    CFG_SCALE   = 2'd1,
    CFG_PROMOTE = 2'd2
  } cn_cfg_e;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_DIV,
    FR_PUSH
  } cn_front_e;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_EXEC,
    BK_WRITE
  } cn_back_e;

  typedef struct packed {
    cn_op_e                   operation;
    logic [LANE_W-1:0]        lane;
    logic [LANE_W-1:0]        shift;
    logic [NODE_W-1:0]        vnode;
    logic signed [LLR_W-1:0]  soft_in;
    logic signed [LLR_W-1:0]  old_c2v;
    logic signed [LLR_W-1:0]  v2c_in;
  } cn_req_t;

  typedef struct packed {
    logic signed [LLR_W-1:0] v2c_out;
    logic signed [LLR_W-1:0] c2v_out;
    logic signed [LLR_W-1:0] soft_out;
  } cn_res_t;

  // classified request as it waits in the queue, row index travels beside it
  typedef struct packed {
    cn_op_e                  op;
    logic [NODE_W-1:0]       node;
    logic signed [LLR_W-1:0] llr;
  } cn_cmd_t;

  typedef struct packed {
    logic              sign;
    logic [NODE_W-1:0] min_node;
    logic [MAG_W-1:0]  second_min;
    logic [MAG_W-1:0]  min_val;
  } cn_row_t;

  typedef struct packed {
    logic full;
    logic empty;
  } cn_qstat_t;

  localparam cn_row_t ROW_RESET = '{
    sign:       1'b0,
    min_node:   '0,
    second_min: INF_MAG,
    min_val:    INF_MAG
  };

endpackage

// ===== src/ldpc_cn_front.sv =====
// front end: takes a request, forms the v2c message and reduces the row index
module ldpc_cn_front import ldpc_cn_pkg::*; #(
  parameter int unsigned MAX_LIFT = 384,
  localparam int unsigned ROW_W = $clog2(MAX_LIFT),
  localparam int unsigned LW    = $clog2(MAX_LIFT + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  cn_req_t               req_i,
  input  logic [LIFT_REG_W-1:0] lift_size_i,
  output logic                  busy_o,
  input  logic                  q_full_i,
  output logic                  q_push_o,
  output cn_cmd_t               q_cmd_o,
  output logic [ROW_W-1:0]      q_row_o
);

  localparam int unsigned DIV_W  = LW + LANE_W - 1;
  localparam int unsigned STEP_W = $clog2(LANE_W);

  function automatic logic signed [LLR_W-1:0] llr_clamp(input logic signed [LLR_W-1:0] x);
    logic signed [LLR_W-1:0] r;
    r = x;
    if (x > INF_P) r = INF_P;
    else if (x < INF_N) r = INF_N;
    return r;
  endfunction

  function automatic logic signed [LLR_W-1:0] llr_sub(input logic signed [LLR_W-1:0] a,
                                                      input logic signed [LLR_W-1:0] b);
    logic signed [LLR_W:0]   t;
    logic signed [LLR_W-1:0] r;
    t = (LLR_W+1)'(a) - (LLR_W+1)'(b);
    if (a == INF_P || a == INF_N) r = (b == a) ? '0 : a;
    else if (b == INF_P || b == INF_N) r = -b;
    else if (t > (LLR_W+1)'(SAT_P)) r = SAT_P;
    else if (t < (LLR_W+1)'(SAT_N)) r = SAT_N;
    else r = t[LLR_W-1:0];
    return r;
  endfunction

  cn_front_e           state_q, state_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic [LANE_W-1:0]   lrem_q, lrem_d, srem_q, srem_d;
  logic [DIV_W-1:0]    div_q, div_d;
  logic [LW-1:0]       lift_q, lift_d, lift_eff;
  cn_cmd_t             cmd_q, cmd_d;
  logic signed [LLR_W-1:0] llr_new;
  int                  row_full;

  always_comb begin
    if (lift_size_i == '0 || int'(lift_size_i) > int'(MAX_LIFT)) begin
      lift_eff = LW'(MAX_LIFT);
    end else begin
      lift_eff = LW'(lift_size_i);
    end
    if (req_i.operation == OP_UPDATE) begin
      llr_new = llr_clamp(req_i.v2c_in);
    end else begin
      llr_new = llr_sub(llr_clamp(req_i.soft_in), llr_clamp(req_i.old_c2v));
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      FR_IDLE: if (start_i) state_d = FR_DIV;
      FR_DIV:  if (step_q == STEP_W'(LANE_W - 1)) state_d = FR_PUSH;
      FR_PUSH: if (!q_full_i) state_d = FR_IDLE;
      default: state_d = FR_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    step_d = step_q;
    lrem_d = lrem_q;
    srem_d = srem_q;
    div_d  = div_q;
    lift_d = lift_q;
    cmd_d  = cmd_q;
    q_push_o = 1'b0;
    case (state_q)
      FR_IDLE: begin
        if (start_i) begin
          step_d = '0;
          lrem_d = req_i.lane;
          srem_d = req_i.shift;
          div_d  = DIV_W'(lift_eff) << (LANE_W - 1);
          lift_d = lift_eff;
          cmd_d  = '{op: req_i.operation, node: req_i.vnode, llr: llr_new};
        end
      end
      FR_DIV: begin
        // one restoring remainder step on lane and shift together
        if (DIV_W'(lrem_q) >= div_q) lrem_d = lrem_q - LANE_W'(div_q);
        if (DIV_W'(srem_q) >= div_q) srem_d = srem_q - LANE_W'(div_q);
        div_d  = div_q >> 1;
        step_d = step_q + STEP_W'(1);
      end
      FR_PUSH: q_push_o = !q_full_i;
      default: ;
    endcase
  end

  always_comb begin
    if (lrem_q >= srem_q) row_full = int'(lrem_q) - int'(srem_q);
    else row_full = int'(lrem_q) + int'(lift_q) - int'(srem_q);
  end

  assign q_row_o = ROW_W'(row_full);
  assign q_cmd_o = cmd_q;
  assign busy_o  = (state_q != FR_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FR_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lrem_q <= lrem_d;
    srem_q <= srem_d;
    div_q  <= div_d;
    lift_q <= lift_d;
    cmd_q  <= cmd_d;
  end

endmodule

// ===== src/ldpc_cn_fifo.sv =====
// short request queue between front and back
module ldpc_cn_fifo import ldpc_cn_pkg::*; #(
  parameter int unsigned DATA_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] din_i,
  input  logic              pop_i,
  output logic [DATA_W-1:0] dout_o,
  output cn_qstat_t         stat_o
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [DATA_W-1:0] slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) wptr_d = (wptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + PTR_W'(1);
    if (pop_i)  rptr_d = (rptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + PTR_W'(1);
    if (push_i && !pop_i) cnt_d = cnt_q + CNT_W'(1);
    else if (pop_i && !push_i) cnt_d = cnt_q - CNT_W'(1);
  end

  assign stat_o.full  = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign dout_o       = slot_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wptr_q] <= din_i;
  end

endmodule

// ===== src/ldpc_cn_back.sv =====
// back end: row memory read-modify-write, scaling and promotion
module ldpc_cn_back import ldpc_cn_pkg::*; #(
  parameter int unsigned MAX_LIFT = 384,
  localparam int unsigned ROW_W = $clog2(MAX_LIFT)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [SCALE_W-1:0] scale_i,
  input  logic [PROMO_W-1:0] promote_i,
  input  logic               q_valid_i,
  input  cn_cmd_t            q_cmd_i,
  input  logic [ROW_W-1:0]   q_row_i,
  output logic               q_pop_o,
  output logic               clearing_o,
  output logic               done_o,
  output cn_res_t            res_o
);

`include "ldpc_layered_min_sum_check_node_macros.svh"

  cn_back_e          state_q, state_d;
  logic [ROW_W-1:0]  clr_q, clr_d;
  cn_cmd_t           cur_q;
  logic [ROW_W-1:0]  cur_row_q;
  cn_row_t           mem [MAX_LIFT];
  cn_row_t           rdata_q;
  cn_row_t           ent_q, ent_d;
  logic [PROD_W-1:0] prod_q, prod_d;
  logic              inf_q, inf_d, neg_q, neg_d;
  logic              done_q, done_d;
  cn_res_t           res_q, res_d;

  logic              mem_we;
  logic [ROW_W-1:0]  mem_waddr;
  cn_row_t           mem_wdata;

  logic [MAG_W-1:0]        mag, m_sel, c2v_mag;
  logic signed [LLR_W-1:0] v, v_neg, c2v, c2v_neg, soft_sum;
  logic signed [LLR_W:0]   psum;
  logic                    is_min, is_two;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_CLEAR: if (clr_q == ROW_W'(MAX_LIFT - 1)) state_d = BK_IDLE;
      BK_IDLE:  if (q_valid_i) state_d = BK_EXEC;
      BK_EXEC:  state_d = BK_WRITE;
      BK_WRITE: state_d = BK_IDLE;
      default:  state_d = BK_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    q_pop_o   = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = cur_row_q;
    mem_wdata = ent_q;
    clr_d     = clr_q;
    done_d    = 1'b0;
    case (state_q)
      BK_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = ROW_RESET;
        clr_d     = clr_q + ROW_W'(1);
      end
      BK_IDLE:  q_pop_o = q_valid_i;
      BK_EXEC:  ;
      BK_WRITE: begin
        mem_we = (cur_q.op == OP_CLEAR) || (cur_q.op == OP_ANALYZE);
        done_d = 1'b1;
      end
      default: ;
    endcase
  end

  // row update and scaling, from the registered read data
  always_comb begin
    v      = cur_q.llr;
    v_neg  = -v;
    mag    = v[LLR_W-1] ? v_neg[MAG_W-1:0] : v[MAG_W-1:0];
    is_min = mag < rdata_q.min_val;
    is_two = mag < rdata_q.second_min;
    m_sel  = (cur_q.node != rdata_q.min_node) ? rdata_q.min_val : rdata_q.second_min;
    ent_d  = ent_q;
    prod_d = PROD_W'(m_sel) * PROD_W'(scale_i) + ROUND_HALF;
    inf_d  = (m_sel == INF_MAG);
    neg_d  = rdata_q.sign ^ v[LLR_W-1];
    case (cur_q.op)
      OP_CLEAR: ent_d = ROW_RESET;
      OP_ANALYZE: begin
        ent_d = rdata_q;
        if (is_two) ent_d.second_min = is_min ? rdata_q.min_val : mag;
        if (is_min) begin
          ent_d.min_val  = mag;
          ent_d.min_node = cur_q.node;
        end
        ent_d.sign = rdata_q.sign ^ v[LLR_W-1];
      end
      default: ;
    endcase
  end

  // signed message and promoted soft bit
  always_comb begin
    c2v_mag = inf_q ? INF_MAG : prod_q[PROD_W-1:SCALE_W];
    c2v     = LLR_W'(c2v_mag);
    c2v_neg = -c2v;
    if (neg_q) c2v = c2v_neg;
    psum = (LLR_W+1)'(c2v) + (LLR_W+1)'(v);
    if (c2v == INF_P || c2v == INF_N) soft_sum = (v == -c2v) ? '0 : c2v;
    else if (v == INF_P || v == INF_N) soft_sum = v;
    else if (psum > $signed({2'b00, promote_i})) soft_sum = INF_P;
    else if (psum < -$signed({2'b00, promote_i})) soft_sum = INF_N;
    else soft_sum = psum[LLR_W-1:0];
    res_d = '0;
    case (cur_q.op)
      OP_ANALYZE: res_d.v2c_out = v;
      OP_UPDATE: begin
        res_d.c2v_out  = c2v;
        res_d.soft_out = soft_sum;
      end
      default: ;
    endcase
  end

  assign clearing_o = (state_q == BK_CLEAR);
  assign done_o     = done_q;
  assign res_o      = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_CLEAR;
      clr_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cur_q     <= q_cmd_i;
      cur_row_q <= q_row_i;
    end
    if (state_q == BK_EXEC) begin
      ent_q  <= ent_d;
      prod_q <= prod_d;
      inf_q  <= inf_d;
      neg_q  <= neg_d;
    end
    if (state_q == BK_WRITE) res_q <= res_d;
  end

  // row memory
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[q_row_i];
  end

  `CN_ASSERT(a_no_req_while_clearing, (state_q == BK_CLEAR) |-> !q_valid_i, "request during clear")
  `CN_ASSERT(a_pop_has_data, q_pop_o |-> q_valid_i, "pop from empty queue")
  `CN_ASSERT(a_min_order, mem_we |-> (mem_wdata.min_val <= mem_wdata.second_min), "minima swapped")
  `CN_ASSERT_NEXT(a_results_spaced, done_q, !done_q, "back-to-back result strobes")

endmodule

// ===== src/ldpc_layered_min_sum_check_node.sv =====
// top level of the layered normalized min-sum check-node processor
//
// a request is taken when start is high and busy is low. the front reduces
// (lane - shift) modulo the lift size with a nine-step restoring remainder
// unit and takes no new request until it has pushed the last one into the
// queue; the back then reads the row, updates or scales it and writes it
// back, and the result shows on res_o with done_o high for exactly one
// cycle. the receiver cannot stall: every result must be taken
// in the cycle it appears. after reset the row memory is swept to its reset
// values, one row per cycle, over all MAX_LIFT rows; busy stays high meanwhile.
// configuration writes are taken at any time but are meant for idle periods.
module ldpc_layered_min_sum_check_node import ldpc_cn_pkg::*; #(
  parameter int unsigned MAX_LIFT = 384
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  cn_req_t              req_i,
  output logic                 done_o,
  output cn_res_t              res_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  localparam int unsigned ROW_W = $clog2(MAX_LIFT);
  localparam int unsigned QD_W  = $bits(cn_cmd_t) + ROW_W;

  // configuration registers
  logic [LIFT_REG_W-1:0] lift_q, lift_d;
  logic [SCALE_W-1:0]    scale_q, scale_d;
  logic [PROMO_W-1:0]    promo_q, promo_d;

  // front to queue to back
  logic             front_busy, clearing, accept;
  logic             q_push, q_pop;
  cn_cmd_t          f_cmd, b_cmd;
  logic [ROW_W-1:0] f_row, b_row;
  logic [QD_W-1:0]  q_dout;
  cn_qstat_t        q_stat;

  // register writes, unknown indexes are dropped
  always_comb begin
    lift_d  = lift_q;
    scale_d = scale_q;
    promo_d = promo_q;
    if (cfg_we_i) begin
      case (cn_cfg_e'(cfg_idx_i))
        CFG_LIFT:    lift_d  = cfg_data_i[LIFT_REG_W-1:0];
        CFG_SCALE:   scale_d = cfg_data_i[SCALE_W-1:0];
        CFG_PROMOTE: promo_d = cfg_data_i[PROMO_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lift_q  <= LIFT_RST;
      scale_q <= SCALE_RST;
      promo_q <= PROMO_RST;
    end else begin
      lift_q  <= lift_d;
      scale_q <= scale_d;
      promo_q <= promo_d;
    end
  end

  // no request while the front is working or the row memory is being swept
  assign busy   = front_busy || clearing;
  assign accept = start && !busy;

  ldpc_cn_front #(
    .MAX_LIFT (MAX_LIFT)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (accept),
    .req_i       (req_i),
    .lift_size_i (lift_q),
    .busy_o      (front_busy),
    .q_full_i    (q_stat.full),
    .q_push_o    (q_push),
    .q_cmd_o     (f_cmd),
    .q_row_o     (f_row)
  );

  ldpc_cn_fifo #(
    .DATA_W (QD_W)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .din_i  ({f_cmd, f_row}),
    .pop_i  (q_pop),
    .dout_o (q_dout),
    .stat_o (q_stat)
  );

  assign b_cmd = q_dout[QD_W-1:ROW_W];
  assign b_row = q_dout[ROW_W-1:0];

  ldpc_cn_back #(
    .MAX_LIFT (MAX_LIFT)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .scale_i    (scale_q),
    .promote_i  (promo_q),
    .q_valid_i  (!q_stat.empty),
    .q_cmd_i    (b_cmd),
    .q_row_i    (b_row),
    .q_pop_o    (q_pop),
    .clearing_o (clearing),
    .done_o     (done_o),
    .res_o      (res_o)
  );

endmodule

// ===== tb/tb_ldpc_layered_min_sum_check_node.sv =====
// self-checking testbench of the layered min-sum check-node processor
module tb_ldpc_layered_min_sum_check_node;
  import ldpc_cn_pkg::*;

  localparam int ROWS           = 384;   // rows in the block's memory
  localparam int LANE_MAX       = 511;   // largest value of a lane or shift field
  localparam int WATCHDOG_LIMIT = 2000;  // covers the clearing sweep after reset many times over
  localparam int SETTLE_CYCLES  = 30;    // longer than one request takes to pass through
  localparam int MAX_PRINTED    = 40;
  localparam int PHASE_ITEMS    = 165;

  // the package has no name for the fourth operation code
  localparam cn_op_e OP_UNUSED = cn_op_e'(2'd3);

  typedef logic signed [LLR_W-1:0] llr_t;

  // predicts every result of the check node and checks what comes back
  class cn_scoreboard;
    logic [MAG_W-1:0]  row_min_mag    [ROWS];
    logic [MAG_W-1:0]  row_second_mag [ROWS];
    logic [NODE_W-1:0] row_min_node   [ROWS];
    logic              row_neg        [ROWS];
    int unsigned       lift, scale, promote;
    cn_res_t           msg_due_q [$];
    int unsigned       mismatches, n_checked, n_settings;
    int unsigned       op_count [4];

    function new();
      for (int r = 0; r < ROWS; r++) clear_row(r);
      lift       = LIFT_RST;
      scale      = SCALE_RST;
      promote    = PROMO_RST;
      mismatches = 0;
      n_checked  = 0;
      n_settings = 1;
      foreach (op_count[i]) op_count[i] = 0;
    endfunction

    function void clear_row(int r);
      row_min_mag[r]    = INF_MAG;
      row_second_mag[r] = INF_MAG;
      row_min_node[r]   = '0;
      row_neg[r]        = 1'b0;
    endfunction

    function void set_config(cn_cfg_e idx, logic [CFG_W-1:0] data);
      case (idx)
        CFG_LIFT:    lift    = data[LIFT_REG_W-1:0];
        CFG_SCALE:   scale   = data[SCALE_W-1:0];
        CFG_PROMOTE: promote = data[PROMO_W-1:0];
        default: ;
      endcase
    endfunction

    // a bad lift size behaves as the full memory
    function int eff_lift();
      if (lift == 0 || lift > ROWS) return ROWS;
      return lift;
    endfunction

    function int row_of(cn_req_t r);
      int l, lane_v, shift_v;
      l       = eff_lift();
      lane_v  = r.lane;
      shift_v = r.shift;
      return (lane_v + l - (shift_v % l)) % l;
    endfunction

    // -128 folds onto minus infinity
    function int llr_of(logic [LLR_W-1:0] raw);
      int v;
      v = $signed(raw);
      if (v < -LLR_INF) v = -LLR_INF;
      return v;
    endfunction

    function bit is_inf(int v);
      return v == LLR_INF || v == -LLR_INF;
    endfunction

    function int llr_diff(int a, int b);
      int nb, t;
      nb = -b;
      if (is_inf(a)) return (nb == -a) ? 0 : a;
      if (is_inf(nb)) return nb;
      t = a + nb;
      if (t > LLR_SAT) t = LLR_SAT;
      if (t < -LLR_SAT) t = -LLR_SAT;
      return t;
    endfunction

    function int promote_sum(int a, int b);
      int t, lim;
      lim = promote;
      if (is_inf(a)) return (b == -a) ? 0 : a;
      if (is_inf(b)) return b;
      t = a + b;
      if (t > lim) return LLR_INF;
      if (t < -lim) return -LLR_INF;
      return t;
    endfunction

    // works out the messages one accepted request gives and queues them
    function void note_request(cn_req_t r);
      cn_res_t          want;
      int               row, v, m, c2v, soft_v;
      logic [MAG_W-1:0] mag;
      bit               hit_min, hit_second, neg;
      want = '0;
      row  = row_of(r);
      op_count[int'(r.operation)]++;
      case (r.operation)
        OP_CLEAR: clear_row(row);
        OP_ANALYZE: begin
          v          = llr_diff(llr_of(r.soft_in), llr_of(r.old_c2v));
          mag        = MAG_W'(v < 0 ? -v : v);
          hit_min    = mag < row_min_mag[row];
          hit_second = mag < row_second_mag[row];
          if (hit_second) row_second_mag[row] = hit_min ? row_min_mag[row] : mag;
          if (hit_min) begin
            row_min_mag[row]  = mag;
            row_min_node[row] = r.vnode;
          end
          row_neg[row] ^= (v < 0);
          want.v2c_out = v[LLR_W-1:0];
        end
        OP_UPDATE: begin
          v = llr_of(r.v2c_in);
          m = (r.vnode != row_min_node[row]) ? row_min_mag[row] : row_second_mag[row];
          if (m != LLR_INF) m = (m * int'(scale) + int'(ROUND_HALF)) >> SCALE_W;
          neg    = row_neg[row] ^ (v < 0);
          c2v    = neg ? -m : m;
          soft_v = promote_sum(c2v, v);
          want.c2v_out  = c2v[LLR_W-1:0];
          want.soft_out = soft_v[LLR_W-1:0];
        end
        default: ;
      endcase
      msg_due_q.push_back(want);
    endfunction

    task report_mismatch(string what, int got, int want);
      mismatches++;
      if (mismatches <= MAX_PRINTED)
        $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    task check_result(cn_res_t got);
      cn_res_t want;
      if (msg_due_q.size() == 0) begin
        report_mismatch("result with no request outstanding", got.c2v_out, 0);
        return;
      end
      want = msg_due_q.pop_front();
      n_checked++;
      if (got.v2c_out !== want.v2c_out) report_mismatch("v2c_out", got.v2c_out, want.v2c_out);
      if (got.c2v_out !== want.c2v_out) report_mismatch("c2v_out", got.c2v_out, want.c2v_out);
      if (got.soft_out !== want.soft_out)
        report_mismatch("soft_out", got.soft_out, want.soft_out);
    endtask

    function int pending();
      return msg_due_q.size();
    endfunction
  endclass

  // every input of the block holds a known value from time zero
  logic                 clk_i      = 1'b0;
  logic                 rst_ni     = 1'b0;
  logic                 start      = 1'b0;
  logic                 busy;
  cn_req_t              req_i      = '0;
  logic                 done_o;
  cn_res_t              res_o;
  logic                 cfg_we_i   = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i  = '0;
  logic [CFG_W-1:0]     cfg_data_i = '0;

  cn_scoreboard sb;
  int unsigned  n_sent;
  int unsigned  burst_left;

  ldpc_layered_min_sum_check_node #(
    .MAX_LIFT(ROWS)
  ) u_dut (
    .clk_i,
    .rst_ni,
    .start,
    .busy,
    .req_i,
    .done_o,
    .res_o,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // results cannot be held off, so every strobe is checked on the edge that ends it
  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_result(res_o);
  end

  // ends the run when neither a request nor a result has moved for too long,
  // which also catches a request whose result never turns up
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (start && !busy) || done_o) quiet = 0;
      else quiet++;
    end
    $display("no traffic for %0d cycles, %0d results still due", WATCHDOG_LIMIT, sb.pending());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // llr values lean on infinities, the out-of-range code and small magnitudes
  // so that ties and opposite infinities turn up often
  function automatic llr_t rand_llr();
    case ($urandom_range(0, 11))
      0:       return INF_P;
      1:       return INF_N;
      2:       return llr_t'(8'h80);
      3, 4, 5: return llr_t'(int'($urandom_range(0, 16)) - 8);
      default: return llr_t'($urandom);
    endcase
  endfunction

  function automatic cn_req_t mk_req(cn_op_e op, int lane, int shift, int node,
                                     int soft_llr, int old, int v2c);
    cn_req_t r;
    r.operation = op;
    r.lane      = LANE_W'(lane);
    r.shift     = LANE_W'(shift);
    r.vnode     = NODE_W'(node);
    r.soft_in   = llr_t'(soft_llr);
    r.old_c2v   = llr_t'(old);
    r.v2c_in    = llr_t'(v2c);
    return r;
  endfunction

  // request aimed at one row, reached through a random shift and a lane that
  // may wrap one or more times around the lift size
  function automatic cn_req_t aimed_req(cn_op_e op, int row, logic [NODE_W-1:0] node);
    cn_req_t r;
    int      l, s, lane;
    l    = sb.eff_lift();
    s    = $urandom_range(0, LANE_MAX);
    lane = (row + s % l) % l;
    lane += l * $urandom_range(0, (LANE_MAX - lane) / l);
    r.operation = op;
    r.lane      = LANE_W'(lane);
    r.shift     = LANE_W'(s);
    r.vnode     = node;
    r.soft_in   = rand_llr();
    r.old_c2v   = rand_llr();
    r.v2c_in    = rand_llr();
    return r;
  endfunction

  // holds start until the request is taken; the sender runs in bursts, and
  // start only drops when a gap follows so it never toggles within one step
  task automatic send_item(cn_req_t r);
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    sb.note_request(r);
    n_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
    end
  endtask

  // registers only change once the block has drained and gone quiet
  task automatic program_regs(int unsigned lift, int unsigned scale, int unsigned promote);
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    while (busy) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_LIFT;
    cfg_data_i <= CFG_W'(lift);
    @(posedge clk_i);
    sb.set_config(CFG_LIFT, CFG_W'(lift));
    cfg_idx_i  <= CFG_SCALE;
    cfg_data_i <= CFG_W'(scale);
    @(posedge clk_i);
    sb.set_config(CFG_SCALE, CFG_W'(scale));
    cfg_idx_i  <= CFG_PROMOTE;
    cfg_data_i <= CFG_W'(promote);
    @(posedge clk_i);
    sb.set_config(CFG_PROMOTE, CFG_W'(promote));
    cfg_we_i <= 1'b0;
    sb.n_settings++;
    burst_left = 0;
  endtask

  // one check row worked as the decoder would: clear it (mostly), fold in a
  // handful of edges, then ask for the new message of each edge; now and then
  // an update names a node that never took part
  task automatic run_sequence();
    int                l, row, deg;
    logic [NODE_W-1:0] nodes [$];
    logic [NODE_W-1:0] nd;
    l   = sb.eff_lift();
    row = $urandom_range(0, l - 1);
    if ($urandom_range(0, 9) != 0) send_item(aimed_req(OP_CLEAR, row, NODE_W'($urandom)));
    deg = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 19) : $urandom_range(2, 7);
    repeat (deg) begin
      nd = ($urandom_range(0, 9) == 0) ? NODE_W'($urandom) : NODE_W'($urandom_range(0, 67));
      nodes.push_back(nd);
      send_item(aimed_req(OP_ANALYZE, row, nd));
    end
    foreach (nodes[i]) begin
      nd = ($urandom_range(0, 7) == 0) ? NODE_W'($urandom) : nodes[i];
      send_item(aimed_req(OP_UPDATE, row, nd));
    end
  endtask

  // mostly row sequences, with fully random requests mixed in as noise
  task automatic run_random(int unsigned count);
    int unsigned stop;
    cn_req_t     r;
    stop = n_sent + count;
    while (n_sent < stop) begin
      if ($urandom_range(0, 6) == 0) begin
        r.operation = cn_op_e'(OP_W'($urandom_range(0, 3)));
        r.lane      = LANE_W'($urandom);
        r.shift     = LANE_W'($urandom);
        r.vnode     = NODE_W'($urandom);
        r.soft_in   = rand_llr();
        r.old_c2v   = rand_llr();
        r.v2c_in    = rand_llr();
        send_item(r);
      end else begin
        run_sequence();
      end
    end
  endtask

  initial begin
    sb         = new();
    n_sent     = 0;
    burst_left = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed requests under the reset settings; busy covers the clearing sweep
    send_item(mk_req(OP_CLEAR,   0,   0,   0,    0,    0,    0));
    // soft and old message the same infinity: difference is zero
    send_item(mk_req(OP_ANALYZE, 0,   0,   5,  127,  127,    0));
    // infinite soft bit passes through
    send_item(mk_req(OP_ANALYZE, 0,   0,   9,  127, -127,    0));
    // infinite old message comes back negated
    send_item(mk_req(OP_ANALYZE, 0,   0,  12,   40, -127,    0));
    // finite difference saturates at both ends
    send_item(mk_req(OP_ANALYZE, 0,   0,   3,  100, -100,    0));
    send_item(mk_req(OP_ANALYZE, 0,   0,   4, -100,  100,    0));
    // out-of-range soft bit reads as minus infinity
    send_item(mk_req(OP_ANALYZE, 0,   0,  67, -128,  100,    0));
    // update of the minimum node takes the second minimum
    send_item(mk_req(OP_UPDATE,  0,   0,   5,    0,    0,   10));
    send_item(mk_req(OP_UPDATE,  0,   0,  66,    0,    0, -128));
    // unused operation code leaves the rows alone
    send_item(mk_req(OP_UNUSED,  511, 511, 127, -1,   -1,   -1));
    // lane and shift beyond the lift size wrap
    send_item(mk_req(OP_CLEAR,   511, 511, 127,   0,   0,    0));
    send_item(mk_req(OP_CLEAR,   0,   1,   0,     0,   0,    0));
    // infinite message flips the row sign but leaves the minimum at infinity
    send_item(mk_req(OP_ANALYZE, 383, 0,   127, -127,  0,    0));
    // opposite infinities in the promoted sum cancel
    send_item(mk_req(OP_UPDATE,  511, 128, 0,     0,   0, -127));
    send_item(mk_req(OP_UPDATE,  383, 0,   1,     0,   0,  127));
    send_item(mk_req(OP_UPDATE,  383, 0,   2,     0,   0,   50));
    // finite minimum scaled and signed from the row parity
    send_item(mk_req(OP_ANALYZE, 383, 0,   20,  100,   0,    0));
    send_item(mk_req(OP_UPDATE,  383, 0,   21,    0,   0,  100));
    send_item(mk_req(OP_CLEAR,   383, 0,   0,     0,   0,    0));
    send_item(mk_req(OP_ANALYZE, 383, 0,   20,  100,   0,    0));
    // sums past the promote limit become infinity of either sign
    send_item(mk_req(OP_UPDATE,  383, 0,   21,    0,   0,  100));
    send_item(mk_req(OP_UPDATE,  383, 0,   21,    0,   0, -100));
    // an infinity in the sum wins
    send_item(mk_req(OP_UPDATE,  383, 0,   21,    0,   0,  127));
    send_item(mk_req(OP_UPDATE,  383, 0,   20,    0,   0, -128));

    // random phases over the register extremes, bad lift sizes included
    program_regs(384, 205, 120);
    run_random(PHASE_ITEMS);
    program_regs(2, 255, 126);
    run_random(PHASE_ITEMS);
    program_regs(1, 1, 1);
    run_random(PHASE_ITEMS);
    program_regs(0, 0, 0);
    run_random(PHASE_ITEMS);
    program_regs(511, 128, 127);
    run_random(PHASE_ITEMS);
    program_regs(7, 77, 60);
    run_random(PHASE_ITEMS);
    program_regs($urandom_range(2, 384), $urandom_range(1, 255), $urandom_range(1, 126));
    run_random(PHASE_ITEMS);
    program_regs(385, 204, 119);
    run_random(PHASE_ITEMS);

    // drain, then let the pipeline settle in case anything extra comes out
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("requests: %0d clear, %0d analyze, %0d update, %0d unused over %0d settings",
             sb.op_count[0], sb.op_count[1], sb.op_count[2], sb.op_count[3], sb.n_settings);
    $display("results compared: %0d, mismatches: %0d", sb.n_checked, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
